// File: sv/fcc_pkg.sv
// Shared types, command codes and microprogram for the flash command controller.
package fcc_pkg;

    localparam int TOTAL_BYTES  = 131072;
    localparam int SECTOR_BYTES = 4096;
    localparam int CELL_AW      = $clog2(TOTAL_BYTES);
    localparam int CFG_AW       = 3;

    localparam logic [CELL_AW-1:0] CHIP_LAST_LARGE = CELL_AW'(TOTAL_BYTES - 1);
    localparam logic [CELL_AW-1:0] CHIP_LAST_SMALL =
        CELL_AW'(((TOTAL_BYTES < 65536) ? TOTAL_BYTES : 65536) - 1);
    localparam logic [15:0] SECTOR_MASK = 16'(SECTOR_BYTES - 1);

    // Configuration register index (byte address 4 * index)
    localparam logic REG_SIZE_MODE = 1'b0;

    // Unlock addresses
    localparam logic [15:0] ADDR_UNLOCK_A = 16'h5555;
    localparam logic [15:0] ADDR_UNLOCK_B = 16'h2AAA;
    localparam logic [15:0] ADDR_BANK     = 16'h0000;

    // Command bytes
    localparam logic [7:0] CMD_UNLOCK_A     = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK_B     = 8'h55;
    localparam logic [7:0] CMD_AUTOSELECT   = 8'h90;
    localparam logic [7:0] CMD_ERASE        = 8'h80;
    localparam logic [7:0] CMD_RESET        = 8'hF0;
    localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
    localparam logic [7:0] CMD_BANK_SELECT  = 8'hB0;
    localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
    localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;

    // Identification bytes
    localparam logic [7:0] ID_MFR_SMALL = 8'h32;
    localparam logic [7:0] ID_DEV_SMALL = 8'h1B;
    localparam logic [7:0] ID_MFR_LARGE = 8'h62;
    localparam logic [7:0] ID_DEV_LARGE = 8'h13;
    localparam logic [7:0] ID_SEL_MFR   = 8'h00;
    localparam logic [7:0] ID_SEL_DEV   = 8'h01;
    localparam logic [7:0] ERASED_BYTE  = 8'hFF;

    typedef enum logic [3:0] {
        CS_ARRAY         = 4'd0,
        CS_UNLOCK1       = 4'd1,
        CS_UNLOCK2       = 4'd2,
        CS_AUTOSEL       = 4'd3,
        CS_ERASE_UNLOCK0 = 4'd4,
        CS_ERASE_UNLOCK1 = 4'd5,
        CS_ERASE_SELECT  = 4'd6,
        CS_PROGRAM       = 4'd8,
        CS_BANK          = 4'd9
    } cmd_state_t;

    typedef enum logic [1:0] {
        RM_ARRAY   = 2'd0,
        RM_AUTOSEL = 2'd1,
        RM_ERASED  = 2'd2
    } read_mode_t;

    typedef enum logic [1:0] {
        STEP_IDLE  = 2'd0,
        STEP_EXEC  = 2'd1,
        STEP_SWEEP = 2'd2
    } step_t;

    typedef enum logic [1:0] {
        COND_START      = 2'd0,
        COND_ERASE_GO   = 2'd1,
        COND_SWEEP_LAST = 2'd2
    } cond_sel_t;

    typedef struct packed {
        logic busy;
        logic latch;
        logic exec;
        logic sweep;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic erase_go;
        logic sweep_last;
    } cond_t;

    typedef struct packed {
        cond_sel_t cond;
        step_t     jump;
        step_t     fall;
        ctrl_t     ctrl;
    } ucode_t;

    // Microprogram: jump when the selected condition holds, else fall through
    function automatic ucode_t ucode_rom(step_t step);
        ucode_t w;
        unique case (step)
            STEP_EXEC:  w = '{cond: COND_ERASE_GO, jump: STEP_SWEEP, fall: STEP_IDLE,
                              ctrl: '{busy: 1'b1, latch: 1'b0, exec: 1'b1, sweep: 1'b0}};
            STEP_SWEEP: w = '{cond: COND_SWEEP_LAST, jump: STEP_IDLE, fall: STEP_SWEEP,
                              ctrl: '{busy: 1'b1, latch: 1'b0, exec: 1'b0, sweep: 1'b1}};
            default:    w = '{cond: COND_START, jump: STEP_EXEC, fall: STEP_IDLE,
                              ctrl: '{busy: 1'b0, latch: 1'b1, exec: 1'b0, sweep: 1'b0}};
        endcase
        return w;
    endfunction

    // Bank bit on top of the window address, wrapped to the array size
    function automatic logic [CELL_AW-1:0] cell_index(logic bank, logic [15:0] addr);
        logic [16:0] full;
        full = {bank, addr};
        return full[CELL_AW-1:0];
    endfunction

endpackage

// File: sv/fcc_ram.sv
// Generic simple dual-port RAM with registered read.
module fcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/fcc_sequencer.sv
// Microprogram step counter and control word decode.
module fcc_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  fcc_pkg::cond_t cond,
    output fcc_pkg::ctrl_t ctrl
);
    import fcc_pkg::*;

    step_t  upc_reg;
    step_t  upc_next;
    ucode_t word;
    logic   taken;

    always_comb
    begin
        word = ucode_rom(upc_reg);
        unique case (word.cond)
            COND_START:      taken = cond.start;
            COND_ERASE_GO:   taken = cond.erase_go;
            COND_SWEEP_LAST: taken = cond.sweep_last;
            default:         taken = 1'b0;
        endcase
        upc_next = taken ? word.jump : word.fall;
        ctrl     = word.ctrl;
    end

    // Come out of reset in the sweep step so the array is cleared first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= STEP_SWEEP;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    a_accept_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cond.start && !ctrl.busy) |=> ctrl.exec)
        else $error("accepted access not executed next cycle");

    a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec |=> !ctrl.exec)
        else $error("execute step repeated");

    a_sweep_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.sweep && !cond.sweep_last) |=> ctrl.sweep)
        else $error("sweep left before last address");

endmodule

// File: sv/fcc_datapath.sv
// Command state, bank, sweep counters, cell array and read data select.
module fcc_datapath (
    input  logic           clk,
    input  logic           rst_n,
    input  fcc_pkg::ctrl_t ctrl,
    output fcc_pkg::cond_t cond,
    input  logic           start,
    input  logic           size_mode,
    input  logic           opcode,
    input  logic [15:0]    bus_address,
    input  logic [7:0]     write_data,
    output logic [7:0]     read_data,
    output logic           result_valid
);
    import fcc_pkg::*;

    logic                opcode_reg;
    logic [15:0]         addr_reg;
    logic [7:0]          data_reg;
    cmd_state_t          cmd_state_reg;
    cmd_state_t          cmd_state_next;
    read_mode_t          read_mode_reg;
    read_mode_t          read_mode_next;
    logic                bank_reg;
    logic                bank_next;
    logic [CELL_AW-1:0]  sweep_addr_reg;
    logic [CELL_AW-1:0]  sweep_last_reg;
    logic                is_write;
    logic                erase_go;
    logic [15:0]         sector_base;
    logic                ram_we;
    logic [CELL_AW-1:0]  ram_waddr;
    logic [7:0]          ram_wdata;
    logic [7:0]          ram_rdata;

    assign is_write    = ctrl.exec && opcode_reg;
    assign erase_go    = is_write && (cmd_state_reg == CS_ERASE_SELECT) &&
                         ((data_reg == CMD_SECTOR_ERASE) || (data_reg == CMD_CHIP_ERASE));
    assign sector_base = addr_reg & ~SECTOR_MASK;

    assign cond.start      = start;
    assign cond.erase_go   = erase_go;
    assign cond.sweep_last = (sweep_addr_reg == sweep_last_reg);

    // Hold the accessed item for the execute step
    always_ff @(posedge clk)
    begin
        if (ctrl.latch && start)
        begin
            opcode_reg <= opcode;
            addr_reg   <= bus_address;
            data_reg   <= write_data;
        end
    end

    // Command machine next state
    always_comb
    begin
        cmd_state_next = cmd_state_reg;
        read_mode_next = read_mode_reg;
        bank_next      = bank_reg;
        if (is_write)
        begin
            unique case (cmd_state_reg)
                CS_UNLOCK1:
                begin
                    if (addr_reg == ADDR_UNLOCK_B && data_reg == CMD_UNLOCK_B)
                        cmd_state_next = CS_UNLOCK2;
                    else
                        cmd_state_next = CS_ARRAY;
                end
                CS_UNLOCK2:
                begin
                    cmd_state_next = CS_ARRAY;
                    read_mode_next = RM_ARRAY;
                    if (addr_reg == ADDR_UNLOCK_A)
                    begin
                        priority if (data_reg == CMD_AUTOSELECT)
                        begin
                            cmd_state_next = CS_AUTOSEL;
                            read_mode_next = RM_AUTOSEL;
                        end
                        else if (data_reg == CMD_ERASE)
                        begin
                            cmd_state_next = CS_ERASE_UNLOCK0;
                            read_mode_next = read_mode_reg;
                        end
                        else if (data_reg == CMD_PROGRAM)
                        begin
                            cmd_state_next = CS_PROGRAM;
                            read_mode_next = read_mode_reg;
                        end
                        else if (data_reg == CMD_BANK_SELECT && size_mode)
                        begin
                            cmd_state_next = CS_BANK;
                            read_mode_next = read_mode_reg;
                        end
                        else
                        begin
                            cmd_state_next = CS_ARRAY;
                        end
                    end
                end
                CS_ERASE_UNLOCK0:
                begin
                    if (addr_reg == ADDR_UNLOCK_A && data_reg == CMD_UNLOCK_A)
                        cmd_state_next = CS_ERASE_UNLOCK1;
                    else
                    begin
                        cmd_state_next = CS_ARRAY;
                        read_mode_next = RM_ARRAY;
                    end
                end
                CS_ERASE_UNLOCK1:
                begin
                    if (addr_reg == ADDR_UNLOCK_B && data_reg == CMD_UNLOCK_B)
                        cmd_state_next = CS_ERASE_SELECT;
                    else
                    begin
                        cmd_state_next = CS_ARRAY;
                        read_mode_next = RM_ARRAY;
                    end
                end
                CS_ERASE_SELECT:
                begin
                    // Command state stays here until the erase-done read or a non-erase write
                    if (erase_go)
                        read_mode_next = RM_ERASED;
                    else
                    begin
                        cmd_state_next = CS_ARRAY;
                        read_mode_next = RM_ARRAY;
                    end
                end
                CS_AUTOSEL:
                begin
                    if (data_reg != CMD_RESET && addr_reg == ADDR_UNLOCK_A &&
                        data_reg == CMD_UNLOCK_A)
                        cmd_state_next = CS_UNLOCK1;
                    else
                    begin
                        cmd_state_next = CS_ARRAY;
                        read_mode_next = RM_ARRAY;
                    end
                end
                CS_PROGRAM:
                begin
                    cmd_state_next = CS_ARRAY;
                    read_mode_next = RM_ARRAY;
                end
                CS_BANK:
                begin
                    if (addr_reg == ADDR_BANK)
                        bank_next = data_reg[0];
                    cmd_state_next = CS_ARRAY;
                    read_mode_next = RM_ARRAY;
                end
                default:
                begin
                    if (addr_reg == ADDR_UNLOCK_A && data_reg == CMD_UNLOCK_A)
                        cmd_state_next = CS_UNLOCK1;
                    else
                        cmd_state_next = CS_ARRAY;
                end
            endcase
        end
        else if (ctrl.exec && read_mode_reg == RM_ERASED)
        begin
            // Erase-done read drops back to array mode
            cmd_state_next = CS_ARRAY;
            read_mode_next = RM_ARRAY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_state_reg <= CS_ARRAY;
            read_mode_reg <= RM_ARRAY;
            bank_reg      <= 1'b0;
        end
        else
        begin
            cmd_state_reg <= cmd_state_next;
            read_mode_reg <= read_mode_next;
            bank_reg      <= bank_next;
        end
    end

    // Sweep counters; reset sets up the full-array clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
            sweep_last_reg <= CHIP_LAST_LARGE;
        end
        else if (erase_go)
        begin
            if (data_reg == CMD_SECTOR_ERASE)
            begin
                sweep_addr_reg <= cell_index(bank_reg, sector_base);
                sweep_last_reg <= cell_index(bank_reg, sector_base | SECTOR_MASK);
            end
            else
            begin
                sweep_addr_reg <= '0;
                sweep_last_reg <= size_mode ? CHIP_LAST_LARGE : CHIP_LAST_SMALL;
            end
        end
        else if (ctrl.sweep)
        begin
            sweep_addr_reg <= sweep_addr_reg + CELL_AW'(1);
        end
    end

    always_comb
    begin
        ram_we    = ctrl.sweep || (is_write && cmd_state_reg == CS_PROGRAM);
        ram_waddr = ctrl.sweep ? sweep_addr_reg : cell_index(bank_reg, addr_reg);
        ram_wdata = ctrl.sweep ? ERASED_BYTE : data_reg;
    end

    fcc_ram #(
        .WIDTH (8),
        .DEPTH (TOTAL_BYTES)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cell_index(bank_reg, bus_address)),
        .rdata (ram_rdata)
    );

    // Read data select
    always_comb
    begin
        result_valid = ctrl.exec && !opcode_reg;
        unique case (read_mode_reg)
            RM_ARRAY:
                read_data = ram_rdata;
            RM_AUTOSEL:
            begin
                if (addr_reg[7:0] == ID_SEL_MFR)
                    read_data = size_mode ? ID_MFR_LARGE : ID_MFR_SMALL;
                else if (addr_reg[7:0] == ID_SEL_DEV)
                    read_data = size_mode ? ID_DEV_LARGE : ID_DEV_SMALL;
                else
                    read_data = 8'h00;
            end
            RM_ERASED:
                read_data = ERASED_BYTE;
            default:
                read_data = 8'h00;
        endcase
    end

endmodule

// File: sv/flash_command_controller.sv
// Top level: register port, microcode sequencer and flash datapath.
//
// Byte-wide flash command controller. Issue one bus access by raising start
// while busy is low; the access is taken at that clock edge. A read returns
// its byte on read_data with result_valid high for exactly one cycle, the
// cycle right after the transfer; there is no way to hold the result off, so
// capture it then. A write returns nothing. Each access is accepted and then
// runs the execute step of the microprogram, so busy drops again
// the cycle after a read result. An erase command walks the cell array
// through its single write port, one byte per cycle: sector erase keeps the
// block busy while it clears 4096 bytes, chip erase while it clears 65536
// (size_mode 0) or 131072 (size_mode 1). After reset the same sweep clears
// all 131072 bytes of the array to 0xFF, so busy stays high until it is
// done, before the first transfer; size_mode can be written over the
// register port meanwhile. Write size_mode only while the block is idle.
module flash_command_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    // access channel
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic [15:0]                bus_address,
    input  logic [7:0]                 write_data,
    output logic [7:0]                 read_data,
    output logic                       result_valid,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fcc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import fcc_pkg::*;

    ctrl_t ctrl;
    cond_t cond;
    logic  size_mode_reg;
    logic  cfg_write;
    logic  cfg_hit;

    // Register file: size_mode at byte address 0, zero-wait access
    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[2] == REG_SIZE_MODE);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_mode_reg <= 1'b0;
        end
        else if (cfg_write && cfg_hit)
        begin
            size_mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata[0] = size_mode_reg;
        end
    end

    // Busy follows the control word of the current step
    assign busy = ctrl.busy;

    fcc_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    fcc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cond         (cond),
        .start        (start),
        .size_mode    (size_mode_reg),
        .opcode       (opcode),
        .bus_address  (bus_address),
        .write_data   (write_data),
        .read_data    (read_data),
        .result_valid (result_valid)
    );

endmodule
